// ===== sv/ccc_pkg.sv =====
// shared types, constants and register map of the code co-occurrence counter
// used by every module of the block, depends on nothing
package ccc_pkg;

    // defaults of the top level parameters
    localparam int TOTAL_CODES_DEF  = 256;
    localparam int MAX_SUBDICTS_DEF = 8;
    localparam int COUNT_BITS_DEF   = 32;

    // field and register widths
    localparam int MODE_W    = 2;
    localparam int INDEX_W   = 8;
    localparam int RESULT_W  = 32;
    localparam int CPP_W     = 4;
    localparam int SDS_W     = 9;
    localparam int SUB_CNT_W = 5;   // holds a code count of up to 31
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    // item modes
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // register indexes, byte address is four times the index
    localparam logic [REG_IDX_W-1:0] REG_INDEX_MODE      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CODES_PER_POINT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SUBDICT_SIZE    = 2'd2;

    // register reset values
    localparam logic             INDEX_MODE_RST      = 1'b0;
    localparam logic [CPP_W-1:0] CODES_PER_POINT_RST = 4'd8;
    localparam logic [SDS_W-1:0] SUBDICT_SIZE_RST    = 9'd32;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] code_index;
        logic [INDEX_W-1:0] read_row;
        logic [INDEX_W-1:0] read_col;
    } ccc_item_t;

    typedef struct packed {
        logic [RESULT_W-1:0] pair_count;
        logic                index_error;
    } ccc_result_t;

    typedef struct packed {
        logic             index_mode;
        logic [CPP_W-1:0] codes_per_point;
        logic [SDS_W-1:0] subdict_size;
    } ccc_cfg_t;

    // controller to datapath
    typedef struct packed {
        logic clear_start;
        logic clear_step;
        logic push;
        logic close_start;
        logic read_issue;
        logic row_load;
        logic pair_step;
        logic out_load;
    } ccc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic push_closes;
        logic clear_last;
        logic a_last;
        logic b_last;
        logic out_free;
    } ccc_status_t;

endpackage

// ===== sv/ccc_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// depends on ccc_pkg for default sizes
module ccc_ram #(
    parameter int WIDTH = ccc_pkg::COUNT_BITS_DEF,
    parameter int DEPTH = ccc_pkg::TOTAL_CODES_DEF * ccc_pkg::TOTAL_CODES_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/ccc_ctrl.sv =====
// controller of the code co-occurrence counter: sequences clear passes,
// point closing and count reads; depends on ccc_pkg
module ccc_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  logic [ccc_pkg::MODE_W-1:0] item_mode,
    output logic                       item_stall,
    input  ccc_pkg::ccc_status_t       status,
    output ccc_pkg::ccc_cmd_t          cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_ROW    = 6'b000100,
        ST_PAIR   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item_mode)
                        ccc_pkg::MODE_CLEAR:
                        begin
                            cmd.clear_start = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        ccc_pkg::MODE_PUSH:
                        begin
                            cmd.push = 1'b1;
                            if (status.push_closes)
                            begin
                                cmd.close_start = 1'b1;
                                state_next      = ST_ROW;
                            end
                        end
                        ccc_pkg::MODE_READ:
                        begin
                            cmd.read_issue = 1'b1;
                            state_next     = ST_RESULT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ROW:
            begin
                cmd.row_load = 1'b1;
                state_next   = ST_PAIR;
            end
            ST_PAIR:
            begin
                cmd.pair_step = 1'b1;
                if (status.b_last)
                begin
                    state_next = status.a_last ? ST_DRAIN : ST_ROW;
                end
            end
            ST_DRAIN:
            begin
                // last increment is written in this cycle
                state_next = ST_IDLE;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/ccc_datapath.sv =====
// datapath of the code co-occurrence counter: point code store, count table
// read-modify-write pipe, clear counter and result register; uses ccc_pkg, ccc_ram
module ccc_datapath #(
    parameter int TOTAL_CODES  = ccc_pkg::TOTAL_CODES_DEF,
    parameter int MAX_SUBDICTS = ccc_pkg::MAX_SUBDICTS_DEF,
    parameter int COUNT_BITS   = ccc_pkg::COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccc_pkg::ccc_item_t   item,
    input  ccc_pkg::ccc_cfg_t    cfg,
    input  ccc_pkg::ccc_cmd_t    cmd,
    output ccc_pkg::ccc_status_t status,
    input  logic                 result_stall,
    output logic                 result_valid,
    output ccc_pkg::ccc_result_t result
);

    localparam int DEPTH  = TOTAL_CODES * TOTAL_CODES;
    localparam int CODE_W = $clog2(TOTAL_CODES);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = (MAX_SUBDICTS > 1) ? $clog2(MAX_SUBDICTS) : 1;
    localparam int CMP_W  = (POS_W + 10 > CODE_W + 1) ? POS_W + 10 : CODE_W + 1;
    localparam int RD_W   = (CODE_W + 1 > ccc_pkg::INDEX_W) ? CODE_W + 1 : ccc_pkg::INDEX_W;
    localparam int SC_W   = ccc_pkg::SUB_CNT_W;

    localparam logic [SC_W-1:0]       MAX_SUB   = SC_W'(MAX_SUBDICTS);
    localparam logic [CMP_W-1:0]      CODE_LIM  = CMP_W'(TOTAL_CODES);
    localparam logic [RD_W-1:0]       READ_LIM  = RD_W'(TOTAL_CODES);
    localparam logic [ADDR_W-1:0]     ROW_STEP  = ADDR_W'(TOTAL_CODES);
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

    // point code store
    logic [CODE_W-1:0] codes_reg [MAX_SUBDICTS];
    logic              kept_reg  [MAX_SUBDICTS];
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              err_reg, err_next;

    // pair sequencing
    logic [POS_W-1:0]  a_reg, a_next;
    logic [POS_W-1:0]  b_reg, b_next;
    logic [SC_W-1:0]   used_reg, used_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic              kept_a_reg, kept_a_next;

    // read-modify-write pipe
    logic              p_valid_reg, p_valid_next;
    logic [ADDR_W-1:0] p_addr_reg, p_addr_next;
    logic              w_valid_reg;
    logic [ADDR_W-1:0] w_addr_reg;
    logic [COUNT_BITS-1:0] w_data_reg, rmw_old, rmw_new;

    // clear pass and read
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              rd_oob_reg, rd_oob_next;
    logic              out_valid_reg, out_valid_next;
    ccc_pkg::ccc_result_t out_data_reg, out_data_next;

    logic [CMP_W-1:0]  code_sum;
    logic              code_ok;
    logic [CODE_W-1:0] code_new;
    logic [SC_W-1:0]   cpp_ext, n_eff, pos_ext;
    logic [POS_W-1:0]  sel_idx;
    logic [CODE_W-1:0] code_sel;
    logic              kept_sel;
    logic [ADDR_W-1:0] pair_addr, rd_addr;
    logic              rd_oob;

    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

    // code of the pushed index, with sub-dictionary offset in local mode
    always_comb
    begin
        if (cfg.index_mode)
        begin
            code_sum = CMP_W'(item.code_index)
                     + CMP_W'(pos_reg) * CMP_W'(cfg.subdict_size);
        end
        else
        begin
            code_sum = CMP_W'(item.code_index);
        end
        code_ok  = (code_sum < CODE_LIM);
        code_new = code_ok ? code_sum[CODE_W-1:0] : '0;
    end

    // effective codes per point, zero acts as one, clipped to the store
    always_comb
    begin
        cpp_ext = SC_W'(cfg.codes_per_point);
        if (cpp_ext == '0)
        begin
            n_eff = SC_W'(1);
        end
        else if (cpp_ext > MAX_SUB)
        begin
            n_eff = MAX_SUB;
        end
        else
        begin
            n_eff = cpp_ext;
        end
    end

    assign pos_ext = SC_W'(pos_reg);

    // one store read per cycle: row code while loading a row, else column code
    assign sel_idx   = cmd.row_load ? a_reg : b_reg;
    assign code_sel  = codes_reg[sel_idx];
    assign kept_sel  = kept_reg[sel_idx];
    assign pair_addr = row_base_reg + ADDR_W'(code_sel);

    assign rd_oob  = (RD_W'(item.read_row) >= READ_LIM) || (RD_W'(item.read_col) >= READ_LIM);
    assign rd_addr = ADDR_W'(item.read_row) * ROW_STEP + ADDR_W'(item.read_col);

    assign status.push_closes = ((pos_ext + SC_W'(1)) >= n_eff);
    assign status.clear_last  = (clr_cnt_reg == LAST_ADDR);
    assign status.a_last      = ((SC_W'(a_reg) + SC_W'(1)) == used_reg);
    assign status.b_last      = ((SC_W'(b_reg) + SC_W'(1)) == used_reg);
    assign status.out_free    = !out_valid_reg || !result_stall;

    // saturating increment, forwarded when the previous write hit the same cell
    assign rmw_old = (w_valid_reg && (w_addr_reg == p_addr_reg)) ? w_data_reg : ram_rdata;
    assign rmw_new = (rmw_old == CNT_MAX) ? rmw_old : rmw_old + COUNT_BITS'(1);

    assign ram_we    = cmd.clear_step || p_valid_reg;
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg : p_addr_reg;
    assign ram_wdata = cmd.clear_step ? '0 : rmw_new;
    assign ram_re    = cmd.read_issue || cmd.pair_step;
    assign ram_raddr = cmd.read_issue ? rd_addr : pair_addr;

    always_comb
    begin
        pos_next       = pos_reg;
        err_next       = err_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        used_next      = used_reg;
        row_base_next  = row_base_reg;
        kept_a_next    = kept_a_reg;
        clr_cnt_next   = clr_cnt_reg;
        rd_oob_next    = rd_oob_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        p_valid_next   = cmd.pair_step && kept_a_reg && kept_sel;
        p_addr_next    = pair_addr;

        if (cmd.clear_start)
        begin
            pos_next     = '0;
            clr_cnt_next = '0;
        end
        if (cmd.clear_step)
        begin
            clr_cnt_next = status.clear_last ? '0 : clr_cnt_reg + ADDR_W'(1);
        end
        if (cmd.push)
        begin
            pos_next = status.push_closes ? '0 : pos_reg + POS_W'(1);
            if (!code_ok)
            begin
                err_next = 1'b1;
            end
        end
        if (cmd.close_start)
        begin
            a_next    = '0;
            b_next    = '0;
            used_next = pos_ext + SC_W'(1);
        end
        if (cmd.row_load)
        begin
            row_base_next = ADDR_W'(code_sel) * ROW_STEP;
            kept_a_next   = kept_sel;
            b_next        = '0;
        end
        if (cmd.pair_step)
        begin
            if (status.b_last)
            begin
                b_next = '0;
                a_next = a_reg + POS_W'(1);
            end
            else
            begin
                b_next = b_reg + POS_W'(1);
            end
        end
        if (cmd.read_issue)
        begin
            rd_oob_next = rd_oob;
        end
        if (cmd.out_load)
        begin
            out_valid_next           = 1'b1;
            out_data_next.pair_count = rd_oob_reg ? '0 : ccc_pkg::RESULT_W'(ram_rdata);
            out_data_next.index_error = err_reg;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            err_reg       <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            used_reg      <= '0;
            clr_cnt_reg   <= '0;
            p_valid_reg   <= 1'b0;
            w_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            err_reg       <= err_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            used_reg      <= used_next;
            clr_cnt_reg   <= clr_cnt_next;
            p_valid_reg   <= p_valid_next;
            w_valid_reg   <= p_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            codes_reg[pos_reg] <= code_new;
            kept_reg[pos_reg]  <= code_ok;
        end
        row_base_reg <= row_base_next;
        kept_a_reg   <= kept_a_next;
        p_addr_reg   <= p_addr_next;
        w_addr_reg   <= p_addr_reg;
        w_data_reg   <= rmw_new;
        rd_oob_reg   <= rd_oob_next;
        out_data_reg <= out_data_next;
    end

    ccc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

// ===== sv/code_cooccurrence_counter.sv =====
// top level of the code co-occurrence counter: apb register block and the
// controller and datapath; uses ccc_pkg, ccc_ctrl, ccc_datapath
//
// counts how often two quantization codes appear in the same point, the
// table b times b-transpose kept as TOTAL_CODES x TOTAL_CODES saturating
// counters of COUNT_BITS bits in one ram. a push beat carries the code
// index of the next sub-dictionary; in local mode the position times
// subdict_size is added. a code that lands outside the table is dropped and
// sets the sticky index_error flag. the push that completes a point (n codes,
// n being codes_per_point clipped to one..MAX_SUBDICTS) walks all n*n ordered
// pairs through one read-modify-write pipe on the count ram, one pair per
// cycle, with a row state before each row to fetch the row code and a
// drain state at the end, holding the item channel stalled throughout;
// other pushes do not stall it. a read beat waits in a result state until
// the output register is free and returns one count with the error flag;
// a result can wait in the output register while further pushes go on.
// rows or columns beyond the table read as zero. the count ram has no
// per-entry valid bits: after reset and after every clear beat the block
// sweeps the whole ram, one entry per cycle, with item_stall high.
// registers (apb, byte address 4*index) may be written at any time the
// block is idle.
module code_cooccurrence_counter #(
    parameter int TOTAL_CODES  = ccc_pkg::TOTAL_CODES_DEF,
    parameter int MAX_SUBDICTS = ccc_pkg::MAX_SUBDICTS_DEF,
    parameter int COUNT_BITS   = ccc_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    // item channel
    input  logic                        item_valid,
    output logic                        item_stall,
    input  ccc_pkg::ccc_item_t          item,

    // result channel
    output logic                        result_valid,
    input  logic                        result_stall,
    output ccc_pkg::ccc_result_t        result,

    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ccc_pkg::PADDR_W-1:0] paddr,
    input  logic [ccc_pkg::PDATA_W-1:0] pwdata,
    output logic [ccc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    ccc_pkg::ccc_cfg_t    cfg_reg, cfg_next;
    ccc_pkg::ccc_cmd_t    cmd;
    ccc_pkg::ccc_status_t status;

    logic                              reg_write;
    logic [ccc_pkg::REG_IDX_W-1:0]     reg_idx;

    // zero wait state port
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[ccc_pkg::PADDR_W-1:2];

    // register writes, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (reg_write)
        begin
            case (reg_idx)
                ccc_pkg::REG_INDEX_MODE:
                begin
                    cfg_next.index_mode = pwdata[0];
                end
                ccc_pkg::REG_CODES_PER_POINT:
                begin
                    cfg_next.codes_per_point = pwdata[ccc_pkg::CPP_W-1:0];
                end
                ccc_pkg::REG_SUBDICT_SIZE:
                begin
                    cfg_next.subdict_size = pwdata[ccc_pkg::SDS_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    // register readback, zero extended
    always_comb
    begin
        case (reg_idx)
            ccc_pkg::REG_INDEX_MODE:
            begin
                prdata = ccc_pkg::PDATA_W'(cfg_reg.index_mode);
            end
            ccc_pkg::REG_CODES_PER_POINT:
            begin
                prdata = ccc_pkg::PDATA_W'(cfg_reg.codes_per_point);
            end
            ccc_pkg::REG_SUBDICT_SIZE:
            begin
                prdata = ccc_pkg::PDATA_W'(cfg_reg.subdict_size);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.index_mode      <= ccc_pkg::INDEX_MODE_RST;
            cfg_reg.codes_per_point <= ccc_pkg::CODES_PER_POINT_RST;
            cfg_reg.subdict_size    <= ccc_pkg::SUBDICT_SIZE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencing: clear sweep, point close, read
    ccc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_mode  (item.mode),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // code store, count ram and result register
    ccc_datapath #(
        .TOTAL_CODES  (TOTAL_CODES),
        .MAX_SUBDICTS (MAX_SUBDICTS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .status       (status),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
